@@ sv/alist_pkg.sv @@
// ----------------------------------------------------------------------------
// alist_pkg
// Shared constants and types for the bounded ordered list with positional
// insert and remove.
// ----------------------------------------------------------------------------
package alist_pkg;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned REQ_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic {
    S_EMPTY = 1'b0,
    S_HOLD  = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic ok;
  } status_t;

endpackage

@@ sv/alist_ctrl.sv @@
// ----------------------------------------------------------------------------
// alist_ctrl
// Handshake controller: tracks whether the result register holds a result
// and tells the datapath when to carry out a request.
// ----------------------------------------------------------------------------
module alist_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  alist_pkg::status_t status_i,
  output alist_pkg::cmd_t   cmd_o,
  output logic              last_ok_o
);

  alist_pkg::state_e state_q, state_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alist_pkg::S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      alist_pkg::S_EMPTY: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
        if (in_valid_i) begin
          state_d = alist_pkg::S_HOLD;
        end
      end
      alist_pkg::S_HOLD: begin
        in_stall_o  = out_stall_i;
        out_valid_o = 1'b1;
        if (!out_stall_i && !in_valid_i) begin
          state_d = alist_pkg::S_EMPTY;
        end
      end
      default: begin
        state_d = alist_pkg::S_EMPTY;
      end
    endcase
    accept      = in_valid_i && !in_stall_o;
    cmd_o.exec  = accept;
  end

  assign last_ok_o = status_i.ok;

endmodule

@@ sv/alist_dp.sv @@
// ----------------------------------------------------------------------------
// alist_dp
// Datapath: entry registers, live count, capacity register and the result
// register. Entries shift in parallel in the cycle an op_ok request is taken.
// ----------------------------------------------------------------------------
module alist_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  alist_pkg::cmd_t                     cmd_i,
  output alist_pkg::status_t                  status_o,
  input  logic                                cfg_we_i,
  input  logic [alist_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic [alist_pkg::REQ_W-1:0]         req_type_i,
  input  logic [alist_pkg::DATA_WIDTH-1:0]    item_value_i,
  input  logic [alist_pkg::CNT_W-1:0]         position_i,
  output logic [alist_pkg::DATA_WIDTH-1:0]    removed_value_o,
  output logic [alist_pkg::CNT_W-1:0]         list_count_o
);

  logic [alist_pkg::DATA_WIDTH-1:0] entries_q [alist_pkg::DEPTH];
  logic [alist_pkg::DATA_WIDTH-1:0] entries_d [alist_pkg::DEPTH];
  logic [alist_pkg::CNT_W-1:0]      count_q, count_d;
  logic [alist_pkg::CNT_W-1:0]      capacity_q;
  logic [alist_pkg::CNT_W-1:0]      limit;
  logic [alist_pkg::DATA_WIDTH-1:0] removed_q, removed_d;
  logic                             ok_q, ok_d;
  logic                             is_app, is_ins, is_rem;
  logic                             op_ok;

  always_comb begin
    limit = (capacity_q > alist_pkg::CNT_W'(alist_pkg::DEPTH)) ?
            alist_pkg::CNT_W'(alist_pkg::DEPTH) : capacity_q;
    is_app = 1'b0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (alist_pkg::req_e'(req_type_i))
      alist_pkg::REQ_APPEND: is_app = 1'b1;
      alist_pkg::REQ_INSERT: is_ins = 1'b1;
      alist_pkg::REQ_REMOVE: is_rem = 1'b1;
      default: begin
        is_app = 1'b0;
      end
    endcase
    op_ok = (is_app && (count_q < limit)) ||
            (is_ins && (count_q < limit) && (position_i <= count_q)) ||
            (is_rem && (count_q != '0) && (position_i < count_q));
  end

  always_comb begin
    logic [alist_pkg::CNT_W-1:0] idx;
    for (int i = 0; i < int'(alist_pkg::DEPTH); i++) begin
      idx          = alist_pkg::CNT_W'(i);
      entries_d[i] = entries_q[i];
      if (is_app && idx == count_q) begin
        entries_d[i] = item_value_i;
      end
      if (is_ins) begin
        if (idx == position_i) begin
          entries_d[i] = item_value_i;
        end else if (i > 0 && idx > position_i && idx <= count_q) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end
      if (is_rem && i < int'(alist_pkg::DEPTH) - 1 && idx >= position_i &&
          (idx + alist_pkg::CNT_W'(1)) < count_q) begin
        entries_d[i] = entries_q[(i < int'(alist_pkg::DEPTH) - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    ok_d      = ok_q;
    removed_d = removed_q;
    if (cmd_i.exec) begin
      ok_d      = op_ok;
      removed_d = '0;
      if (op_ok) begin
        if (is_rem) begin
          count_d   = count_q - alist_pkg::CNT_W'(1);
          removed_d = entries_q[position_i[alist_pkg::IDX_W-1:0]];
        end else begin
          count_d = count_q + alist_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      capacity_q <= alist_pkg::CNT_W'(8);
      ok_q       <= 1'b0;
      removed_q  <= '0;
    end else begin
      count_q   <= count_d;
      ok_q      <= ok_d;
      removed_q <= removed_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && op_ok) begin
      for (int i = 0; i < int'(alist_pkg::DEPTH); i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  assign status_o.ok     = ok_q;
  assign removed_value_o = removed_q;
  assign list_count_o    = count_q;

endmodule

@@ sv/array_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// array_list_insert_remove
// Bounded ordered list of data words with append, positional insert and
// positional remove; one result per request.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         cfg_we_i                  cfg_wdata_i (capacity)
//   in       in         in_valid_i / in_stall_o   req_type_i, item_value_i,
//                                                 position_i
//   out      out        out_valid_o / out_stall_i ok_o, removed_value_o,
//                                                 list_count_o
//
// A request is carried out in the cycle it is taken; its result appears in
// the next cycle. One request per cycle is sustained while out_stall_i is low,
// entries shifting in parallel. A result waiting under stall holds off new
// requests until the stall lifts. Reset empties the list and sets the
// capacity to eight; entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module array_list_insert_remove (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [alist_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [alist_pkg::REQ_W-1:0]      req_type_i,
  input  logic [alist_pkg::DATA_WIDTH-1:0] item_value_i,
  input  logic [alist_pkg::CNT_W-1:0]      position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [alist_pkg::DATA_WIDTH-1:0] removed_value_o,
  output logic [alist_pkg::CNT_W-1:0]      list_count_o
);

  alist_pkg::cmd_t    cmd;
  alist_pkg::status_t status;

  alist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .last_ok_o   (ok_o)
  );

  alist_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .position_i      (position_i),
    .removed_value_o (removed_value_o),
    .list_count_o    (list_count_o)
  );

endmodule

@@ sv/alist_checker.sv @@
// ----------------------------------------------------------------------------
// alist_checker
// Port-level checks for the list block, bound to the top level.
// ----------------------------------------------------------------------------
module alist_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             ok_o,
  input logic [alist_pkg::DATA_WIDTH-1:0] removed_value_o,
  input logic [alist_pkg::CNT_W-1:0]      list_count_o
);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_count_o <= alist_pkg::CNT_W'(alist_pkg::DEPTH))
    else $error("List count exceeds the depth.");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> removed_value_o == '0)
    else $error("Refused request returned a non-zero value.");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(list_count_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("Count changed without an accepted request.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) &&
    $stable(removed_value_o) && $stable(list_count_o))
    else $error("Stalled result did not hold.");

endmodule

bind array_list_insert_remove alist_checker u_alist_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .ok_o            (ok_o),
  .removed_value_o (removed_value_o),
  .list_count_o    (list_count_o)
);
